// ----- rtl/core/occ_ray_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package occ_ray_pkg;

    // Geometry and storage defaults
    localparam int GRID_SIDE_DEF     = 64;
    localparam int LOG_ODDS_BITS_DEF = 16;

    // Fixed field widths
    localparam int COORD_W   = 6;
    localparam int DIM_W     = 7;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 12;
    localparam int VALUE_W   = 16;
    localparam int ERR_W     = 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INTEGRATE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ      = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_OCCUPIED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREED    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEARED  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIT_INC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_INC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ODDS_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ODDS_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_W    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_H    = 3'd5;

    // Register reset values
    localparam logic signed [CFG_W-1:0] HIT_INC_RST  = 16'sd217;
    localparam logic signed [CFG_W-1:0] PASS_INC_RST = -16'sd104;
    localparam logic signed [CFG_W-1:0] ODDS_MIN_RST = -16'sd512;
    localparam logic signed [CFG_W-1:0] ODDS_MAX_RST = 16'sd896;
    localparam logic [DIM_W-1:0]        GRID_W_RST   = 7'd64;
    localparam logic [DIM_W-1:0]        GRID_H_RST   = 7'd64;

endpackage

`default_nettype wire

// ----- rtl/core/occ_ray_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module occ_ray_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire [WIDTH-1:0]          wr_data,
    input  wire                      rd_en,
    input  wire [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word; read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/occupancy_ray_update_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Log-odds occupancy grid with Bresenham beam update.
// Input channel (s_*): one item per operation: integrate a beam, read a cell or
// clear the map. Result channel (m_*): newly occupied / newly freed cells of a
// beam, one read result, or one clear-done result; the final result caused by
// an item carries m_last_of_run. Registers are written over the cfg_* channel,
// which is always ready; the user must write them only while the block is idle,
// which the block itself does not enforce. A beam is walked one cell per cycle,
// unless a stall holds the walk, through a read-modify-write of the map RAM
// (one read and one write port, registered read); a clear writes one RAM word
// per cycle. The next item is taken only once the current one is done.
// The block handles one item at a time; s_ready is high only when idle.
// Reset: after aresetn is released all GRID_SIDE*GRID_SIDE words of the map RAM
// are swept to zero, during which s_ready stays low.
// Stall: one transition is held back to mark the last result; when a second one
// is ready and the output register is still full, the walk holds in place.
module occupancy_ray_update_core
    import occ_ray_pkg::*;
#(
    parameter int GRID_SIDE     = GRID_SIDE_DEF,
    parameter int LOG_ODDS_BITS = LOG_ODDS_BITS_DEF
) (
    input  wire                       aclk,
    input  wire                       aresetn,

    input  wire                       cfg_valid,
    output logic                      cfg_ready,
    input  wire  [CFG_IDX_W-1:0]      cfg_index,
    input  wire  [CFG_W-1:0]          cfg_data,

    input  wire                       s_valid,
    output logic                      s_ready,
    input  wire  [OP_W-1:0]           s_operation,
    input  wire  [COORD_W-1:0]        s_start_x,
    input  wire  [COORD_W-1:0]        s_start_y,
    input  wire  [COORD_W-1:0]        s_end_x,
    input  wire  [COORD_W-1:0]        s_end_y,
    input  wire                       s_endpoint_hit,

    output logic                      m_valid,
    input  wire                       m_ready,
    output logic [KIND_W-1:0]         m_result_kind,
    output logic [INDEX_W-1:0]        m_cell_index,
    output logic signed [VALUE_W-1:0] m_cell_value,
    output logic                      m_last_of_run
);

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LIN_W  = COORD_W + DIM_W;
    localparam int SUM_W  = ((LOG_ODDS_BITS > CFG_W) ? LOG_ODDS_BITS : CFG_W) + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [DIM_W-1:0]  SIDE_DIM  = DIM_W'(GRID_SIDE);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (LOG_ODDS_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO =
        SUM_W'(-(64'sd1 <<< (LOG_ODDS_BITS - 1)));

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FLUSH,
        ST_READ,
        ST_DONE
    } state_t;

    // Registers
    state_t                   state_reg,      state_next;
    logic signed [CFG_W-1:0]  hit_inc_reg,    hit_inc_next;
    logic signed [CFG_W-1:0]  pass_inc_reg,   pass_inc_next;
    logic signed [CFG_W-1:0]  odds_min_reg,   odds_min_next;
    logic signed [CFG_W-1:0]  odds_max_reg,   odds_max_next;
    logic [DIM_W-1:0]         grid_w_reg,     grid_w_next;
    logic [DIM_W-1:0]         grid_h_reg,     grid_h_next;

    logic [COORD_W-1:0]       walk_x_reg,     walk_x_next;
    logic [COORD_W-1:0]       walk_y_reg,     walk_y_next;
    logic [COORD_W-1:0]       end_x_reg,      end_x_next;
    logic [COORD_W-1:0]       end_y_reg,      end_y_next;
    logic [COORD_W-1:0]       dx_reg,         dx_next;
    logic [COORD_W-1:0]       dy_reg,         dy_next;
    logic signed [ERR_W-1:0]  err_reg,        err_next;
    logic [1:0]               signs_reg,      signs_next;
    logic                     hit_reg,        hit_next;

    logic                     u_valid_reg,    u_valid_next;
    logic [ADDR_W-1:0]        u_addr_reg,     u_addr_next;
    logic                     u_hit_reg,      u_hit_next;

    logic                     pend_valid_reg, pend_valid_next;
    logic [KIND_W-1:0]        pend_kind_reg,  pend_kind_next;
    logic [ADDR_W-1:0]        pend_addr_reg,  pend_addr_next;
    logic [VALUE_W-1:0]       pend_value_reg, pend_value_next;

    logic                     read_ok_reg,    read_ok_next;
    logic [ADDR_W-1:0]        read_addr_reg,  read_addr_next;
    logic [ADDR_W-1:0]        clr_cnt_reg,    clr_cnt_next;
    logic                     clr_report_reg, clr_report_next;

    logic                     m_valid_reg,    m_valid_next;
    logic [KIND_W-1:0]        m_kind_reg,     m_kind_next;
    logic [INDEX_W-1:0]       m_index_reg,    m_index_next;
    logic [VALUE_W-1:0]       m_value_reg,    m_value_next;
    logic                     m_last_reg,     m_last_next;

    // RAM ports
    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [LOG_ODDS_BITS-1:0] ram_wr_data;
    logic                     ram_rd_en;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic [LOG_ODDS_BITS-1:0] ram_rd_data;

    // Combinational helpers
    logic [DIM_W-1:0]         eff_w;
    logic [DIM_W-1:0]         eff_h;
    logic                     start_ok;
    logic                     end_ok;
    logic [COORD_W-1:0]       lin_x;
    logic [COORD_W-1:0]       lin_y;
    logic [LIN_W-1:0]         lin_idx;
    logic [ADDR_W-1:0]        cell_addr;
    logic                     at_end;
    logic signed [ERR_W:0]    err2;
    logic                     step_x;
    logic                     step_y;
    logic signed [ERR_W-1:0]  dx_ext;
    logic signed [ERR_W-1:0]  dy_ext;

    logic signed [SUM_W-1:0]  old_ext;
    logic signed [SUM_W-1:0]  delta_ext;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  clamp_hi;
    logic signed [SUM_W-1:0]  clamp_lo;
    logic signed [SUM_W-1:0]  sat_val;
    logic signed [SUM_W-1:0]  new_ext;
    logic [LOG_ODDS_BITS-1:0] new_val;
    logic                     was_pos;
    logic                     now_pos;
    logic                     trans;
    logic                     out_free;
    logic                     stall;
    logic                     issue;
    logic                     s_accept;

    occ_ray_ram #(
        .WIDTH (LOG_ODDS_BITS),
        .DEPTH (DEPTH)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Effective grid size and bounds checks
    assign eff_w    = (grid_w_reg > SIDE_DIM) ? SIDE_DIM : grid_w_reg;
    assign eff_h    = (grid_h_reg > SIDE_DIM) ? SIDE_DIM : grid_h_reg;
    assign start_ok = ({1'b0, s_start_x} < eff_w) && ({1'b0, s_start_y} < eff_h);
    assign end_ok   = ({1'b0, s_end_x} < eff_w) && ({1'b0, s_end_y} < eff_h);

    // Linear cell index, shared by the walk and the read
    assign lin_x     = (state_reg == ST_IDLE) ? s_start_x : walk_x_reg;
    assign lin_y     = (state_reg == ST_IDLE) ? s_start_y : walk_y_reg;
    assign lin_idx   = LIN_W'(lin_y) * LIN_W'(eff_w) + LIN_W'(lin_x);
    assign cell_addr = ADDR_W'(lin_idx);

    // Bresenham step decision
    assign at_end = (walk_x_reg == end_x_reg) && (walk_y_reg == end_y_reg);
    assign err2   = {err_reg, 1'b0};
    assign dx_ext = $signed({2'b00, dx_reg});
    assign dy_ext = $signed({2'b00, dy_reg});
    assign step_x = err2 > -$signed({dy_ext[ERR_W-1], dy_ext});
    assign step_y = err2 < $signed({dx_ext[ERR_W-1], dx_ext});

    // Cell update: add, clamp to the window, saturate to the cell width
    assign old_ext   = SUM_W'($signed(ram_rd_data));
    assign delta_ext = SUM_W'(u_hit_reg ? hit_inc_reg : pass_inc_reg);
    assign sum       = old_ext + delta_ext;
    assign clamp_hi  = (sum > SUM_W'(odds_max_reg)) ? SUM_W'(odds_max_reg) : sum;
    assign clamp_lo  = (clamp_hi < SUM_W'(odds_min_reg)) ? SUM_W'(odds_min_reg) : clamp_hi;
    assign sat_val   = (clamp_lo > SAT_HI) ? SAT_HI :
                       ((clamp_lo < SAT_LO) ? SAT_LO : clamp_lo);
    assign new_val   = LOG_ODDS_BITS'(sat_val);
    assign new_ext   = SUM_W'($signed(new_val));
    assign was_pos   = old_ext > 0;
    assign now_pos   = sat_val > 0;
    assign trans     = u_valid_reg && (was_pos != now_pos);

    // Hold the walk when a transition has no room to go
    assign out_free = !m_valid_reg || m_ready;
    assign stall    = trans && pend_valid_reg && !out_free;
    assign issue    = (state_reg == ST_WALK) && !stall;
    assign s_accept = s_valid && s_ready;

    // RAM port selection
    assign ram_wr_en   = (state_reg == ST_CLEAR) || (u_valid_reg && !stall);
    assign ram_wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : u_addr_reg;
    assign ram_wr_data = (state_reg == ST_CLEAR) ? '0 : new_val;
    assign ram_rd_en   = issue || (s_accept && (s_operation == OP_READ));
    assign ram_rd_addr = cell_addr;

    // Ports
    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_cell_index  = m_index_reg;
    assign m_cell_value  = $signed(m_value_reg);
    assign m_last_of_run = m_last_reg;

    always_comb begin
        state_next      = state_reg;
        hit_inc_next    = hit_inc_reg;
        pass_inc_next   = pass_inc_reg;
        odds_min_next   = odds_min_reg;
        odds_max_next   = odds_max_reg;
        grid_w_next     = grid_w_reg;
        grid_h_next     = grid_h_reg;
        walk_x_next     = walk_x_reg;
        walk_y_next     = walk_y_reg;
        end_x_next      = end_x_reg;
        end_y_next      = end_y_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        err_next        = err_reg;
        signs_next      = signs_reg;
        hit_next        = hit_reg;
        u_valid_next    = u_valid_reg;
        u_addr_next     = u_addr_reg;
        u_hit_next      = u_hit_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_addr_next  = pend_addr_reg;
        pend_value_next = pend_value_reg;
        read_ok_next    = read_ok_reg;
        read_addr_next  = read_addr_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_index_next    = m_index_reg;
        m_value_next    = m_value_reg;
        m_last_next     = m_last_reg;

        // Register writes
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_HIT_INC:  hit_inc_next  = $signed(cfg_data);
                REG_PASS_INC: pass_inc_next = $signed(cfg_data);
                REG_ODDS_MIN: odds_min_next = $signed(cfg_data);
                REG_ODDS_MAX: odds_max_next = $signed(cfg_data);
                REG_GRID_W:   grid_w_next   = cfg_data[DIM_W-1:0];
                REG_GRID_H:   grid_h_next   = cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end

        // Retire the cell in the update stage; park its transition
        if (!stall) begin
            u_valid_next = 1'b0;
            if (trans) begin
                if (pend_valid_reg) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = pend_kind_reg;
                    m_index_next = INDEX_W'(pend_addr_reg);
                    m_value_next = pend_value_reg;
                    m_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_kind_next  = now_pos ? KIND_OCCUPIED : KIND_FREED;
                pend_addr_next  = u_addr_reg;
                pend_value_next = new_ext[VALUE_W-1:0];
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = clr_report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_operation)
                        OP_INTEGRATE: begin
                            if (start_ok && end_ok) begin
                                walk_x_next = s_start_x;
                                walk_y_next = s_start_y;
                                end_x_next  = s_end_x;
                                end_y_next  = s_end_y;
                                dx_next     = (s_end_x > s_start_x) ? s_end_x - s_start_x
                                                                    : s_start_x - s_end_x;
                                dy_next     = (s_end_y > s_start_y) ? s_end_y - s_start_y
                                                                    : s_start_y - s_end_y;
                                err_next    = $signed({2'b00, dx_next}) - $signed({2'b00, dy_next});
                                signs_next  = {s_start_y < s_end_y, s_start_x < s_end_x};
                                hit_next    = s_endpoint_hit;
                                state_next  = ST_WALK;
                            end
                        end
                        OP_READ: begin
                            read_ok_next   = start_ok;
                            read_addr_next = cell_addr;
                            state_next     = ST_READ;
                        end
                        OP_CLEAR: begin
                            clr_cnt_next    = '0;
                            clr_report_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                // Issue one cell read and advance the line
                if (issue) begin
                    u_valid_next = 1'b1;
                    u_addr_next  = cell_addr;
                    u_hit_next   = at_end && hit_reg;
                    if (at_end) begin
                        state_next = ST_DRAIN;
                    end else begin
                        if (step_x) begin
                            walk_x_next = signs_reg[0] ? walk_x_reg + 1'b1 : walk_x_reg - 1'b1;
                        end
                        if (step_y) begin
                            walk_y_next = signs_reg[1] ? walk_y_reg + 1'b1 : walk_y_reg - 1'b1;
                        end
                        err_next = err_reg - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);
                    end
                end
            end
            ST_DRAIN: begin
                if (!stall) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // Send the held transition as the last of the run
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = pend_kind_reg;
                    m_index_next    = INDEX_W'(pend_addr_reg);
                    m_value_next    = pend_value_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_READ;
                    m_index_next = read_ok_reg ? INDEX_W'(read_addr_reg) : '0;
                    m_value_next = read_ok_reg ? old_ext[VALUE_W-1:0] : '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = KIND_CLEARED;
                    m_index_next    = '0;
                    m_value_next    = '0;
                    m_last_next     = 1'b1;
                    clr_report_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            hit_inc_reg    <= HIT_INC_RST;
            pass_inc_reg   <= PASS_INC_RST;
            odds_min_reg   <= ODDS_MIN_RST;
            odds_max_reg   <= ODDS_MAX_RST;
            grid_w_reg     <= GRID_W_RST;
            grid_h_reg     <= GRID_H_RST;
            walk_x_reg     <= '0;
            walk_y_reg     <= '0;
            err_reg        <= '0;
            signs_reg      <= '0;
            u_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hit_inc_reg    <= hit_inc_next;
            pass_inc_reg   <= pass_inc_next;
            odds_min_reg   <= odds_min_next;
            odds_max_reg   <= odds_max_next;
            grid_w_reg     <= grid_w_next;
            grid_h_reg     <= grid_h_next;
            walk_x_reg     <= walk_x_next;
            walk_y_reg     <= walk_y_next;
            err_reg        <= err_next;
            signs_reg      <= signs_next;
            u_valid_reg    <= u_valid_next;
            pend_valid_reg <= pend_valid_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            m_valid_reg    <= m_valid_next;
        end
        end_x_reg      <= end_x_next;
        end_y_reg      <= end_y_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        hit_reg        <= hit_next;
        u_addr_reg     <= u_addr_next;
        u_hit_reg      <= u_hit_next;
        pend_kind_reg  <= pend_kind_next;
        pend_addr_reg  <= pend_addr_next;
        pend_value_reg <= pend_value_next;
        read_ok_reg    <= read_ok_next;
        read_addr_reg  <= read_addr_next;
        m_kind_reg     <= m_kind_next;
        m_index_reg    <= m_index_next;
        m_value_reg    <= m_value_next;
        m_last_reg     <= m_last_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/occ_ray_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module occ_ray_checker
    import occ_ray_pkg::*;
(
    input wire                       aclk,
    input wire                       aresetn,
    input wire                       s_ready,
    input wire                       m_valid,
    input wire                       m_ready,
    input wire [KIND_W-1:0]          m_result_kind,
    input wire [INDEX_W-1:0]         m_cell_index,
    input wire signed [VALUE_W-1:0]  m_cell_value,
    input wire                       m_last_of_run
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind)
            && $stable(m_cell_index) && $stable(m_cell_value) && $stable(m_last_of_run))
        else $error("result changed while stalled");

    // Read and clear results end their run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_result_kind == KIND_READ || m_result_kind == KIND_CLEARED)
            |-> m_last_of_run)
        else $error("single result without last flag");

    // Clear-done carries zero index and value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_CLEARED |-> m_cell_index == '0 && m_cell_value == '0)
        else $error("clear-done result not zero");

    // Map sweep after reset: no item taken, no result shown
    assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !s_ready && !m_valid)
        else $error("block active right after reset");

endmodule

bind occupancy_ray_update_core occ_ray_checker u_occ_ray_checker (.*);

`default_nettype wire
